// ----- hw/rtl/look_at_view_matrix_assert.svh -----
// Assertion macros for the look-at view matrix block.
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define LAV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true out of reset.
`define LAV_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LAV_ASSERT(lbl, clk, rst_n, prop, msg)
`define LAV_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- hw/rtl/lavm_pkg.sv -----
package lavm_pkg;

	// Working width of vectors fed to the normaliser
	localparam int VEC_W    = 64;
	// Largest magnitude is block shifted into [2^(NORM_W-1), 2^NORM_W)
	localparam int NORM_W   = 30;
	localparam int NORM_TOP = NORM_W - 1;
	// Root bits of a sum of three NORM_W-bit squares
	localparam int SQ_STEPS = NORM_W + 1;
	// Leading-one search split into chunks
	localparam int CHUNK_W  = 16;
	localparam int N_CHUNK  = VEC_W / CHUNK_W;
	localparam int CHUNK_IW = $clog2(N_CHUNK);
	localparam int LO_W     = $clog2(CHUNK_W);
	localparam int POS_W    = CHUNK_IW + LO_W;

	localparam int ROWS = 3;

	// Row codes
	localparam logic [1:0] ROW_X = 2'd0;
	localparam logic [1:0] ROW_Y = 2'd1;
	localparam logic [1:0] ROW_Z = 2'd2;

	typedef struct packed {
		logic signed [31:0] eye_x;
		logic signed [31:0] eye_y;
		logic signed [31:0] eye_z;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] upvec_x;
		logic signed [31:0] upvec_y;
		logic signed [31:0] upvec_z;
	} lavm_in_t;

	typedef struct packed {
		logic        [1:0]  row_index;
		logic signed [31:0] col_0;
		logic signed [31:0] col_1;
		logic signed [31:0] col_2;
		logic signed [31:0] translation;
		logic               degenerate;
		logic               last_row;
	} lavm_out_t;

endpackage

// ----- hw/rtl/lavm_norm.sv -----
module lavm_norm
	import lavm_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int SIDE_W    = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic [2:0][VEC_W-1:0]               in_vec,
	input  logic [SIDE_W-1:0]                   in_side,
	output logic                                out_vld,
	output logic                                out_zero,
	output logic [2:0][FRAC_BITS+1:0]           out_vec,
	output logic [SIDE_W-1:0]                   out_side
);

	localparam int QB     = FRAC_BITS + 1;
	localparam int AX_W   = FRAC_BITS + 2;
	localparam int NUM_W  = NORM_W + FRAC_BITS + 1;
	localparam int SQ_W   = 2 * NORM_W;
	localparam int SUM_W  = 2 * SQ_STEPS;
	localparam int ROOT_W = SQ_STEPS;
	localparam int REM_W  = SQ_STEPS + 3;

	typedef struct packed {
		logic              vld;
		logic              zero;
		logic [2:0]        neg;
		logic [SIDE_W-1:0] side;
	} ctl_t;

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic [2:0][VEC_W-1:0]  mag_s1, mag_s2, mag_s3, mag_s4;
	logic [VEC_W-1:0]       mx_s2;
	logic [CHUNK_IW-1:0]    hi_s3;
	logic [CHUNK_W-1:0]     chunk_s3;
	logic [POS_W-1:0]       pos_s4;
	logic [2:0][NORM_W-1:0] mn_s5, mn_s6;
	logic [2:0][SQ_W-1:0]   sq_s6;

	// Square-root stages, entry k registered at stage 7+k
	ctl_t                   sqr_ctl_s7  [SQ_STEPS+1];
	logic [REM_W-1:0]       sqr_rem_s7  [SQ_STEPS+1];
	logic [ROOT_W-1:0]      sqr_root_s7 [SQ_STEPS+1];
	logic [SUM_W-1:0]       sqr_rest_s7 [SQ_STEPS+1];
	logic [2:0][NORM_W-1:0] sqr_mn_s7   [SQ_STEPS+1];

	// Divider stages, three lanes sharing one root
	ctl_t                   dv_ctl_s8 [QB+1];
	logic [ROOT_W-1:0]      dv_n_s8   [QB+1];
	logic [2:0][ROOT_W-1:0] dv_rem_s8 [QB+1];
	logic [2:0][QB-1:0]     dv_lo_s8  [QB+1];

	logic [2:0]             neg1;
	logic [2:0][VEC_W-1:0]  mag1;
	logic [VEC_W-1:0]       mx2;
	logic [CHUNK_IW-1:0]    hi3;
	logic [CHUNK_W-1:0]     chunk3;
	logic [LO_W-1:0]        lo4;
	logic [POS_W-1:0]       rsh5, lsh5;
	logic [2:0][NORM_W-1:0] mn5;
	logic [2:0][NUM_W-1:0]  num_p;
	logic [2:0][QB-1:0]     q_f;

	// Take magnitudes and signs
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg1[i] = in_vec[i][VEC_W-1];
			mag1[i] = neg1[i] ? (VEC_W'(0) - in_vec[i]) : in_vec[i];
		end
	end

	// Largest magnitude
	always_comb begin
		mx2 = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];
		if (mag_s1[2] > mx2) begin
			mx2 = mag_s1[2];
		end
	end

	// Leading-one search, chunk then bit
	always_comb begin
		hi3    = '0;
		chunk3 = mx_s2[CHUNK_W-1:0];
		for (int g = 0; g < N_CHUNK; g++) begin
			if (mx_s2[g*CHUNK_W +: CHUNK_W] != '0) begin
				hi3    = CHUNK_IW'(g);
				chunk3 = mx_s2[g*CHUNK_W +: CHUNK_W];
			end
		end
	end

	always_comb begin
		lo4 = '0;
		for (int b = 0; b < CHUNK_W; b++) begin
			if (chunk_s3[b]) begin
				lo4 = LO_W'(b);
			end
		end
	end

	// Block shift so the largest magnitude tops out at bit NORM_TOP
	always_comb begin
		rsh5 = pos_s4 - POS_W'(NORM_TOP);
		lsh5 = POS_W'(NORM_TOP) - pos_s4;
		for (int i = 0; i < 3; i++) begin
			if (pos_s4 > POS_W'(NORM_TOP)) begin
				mn5[i] = NORM_W'(mag_s4[i] >> rsh5);
			end else begin
				mn5[i] = NORM_W'(mag_s4[i] << lsh5);
			end
		end
	end

	// Control through the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			sqr_ctl_s7[0] <= '0;
		end else begin
			ctl_s1 <= '{vld: in_vld, zero: 1'b0, neg: neg1, side: in_side};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= '{vld: ctl_s2.vld, zero: (mx_s2 == '0), neg: ctl_s2.neg,
				side: ctl_s2.side};
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			sqr_ctl_s7[0] <= ctl_s6;
		end
	end

	// Payload through the front stages
	always_ff @(posedge clk) begin
		mag_s1   <= mag1;
		mag_s2   <= mag_s1;
		mx_s2    <= mx2;
		mag_s3   <= mag_s2;
		hi_s3    <= hi3;
		chunk_s3 <= chunk3;
		mag_s4   <= mag_s3;
		pos_s4   <= {hi_s3, lo4};
		mn_s5    <= mn5;
		mn_s6    <= mn_s5;
		for (int i = 0; i < 3; i++) begin
			sq_s6[i] <= SQ_W'(mn_s5[i]) * SQ_W'(mn_s5[i]);
		end
		sqr_rem_s7[0]  <= '0;
		sqr_root_s7[0] <= '0;
		sqr_rest_s7[0] <= SUM_W'(sq_s6[0]) + SUM_W'(sq_s6[1]) + SUM_W'(sq_s6[2]);
		sqr_mn_s7[0]   <= mn_s6;
	end

	// Square root, one root bit a stage
	for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
		logic [REM_W-1:0] rem2;
		logic [REM_W-1:0] trial;
		logic             ge;

		assign rem2  = {sqr_rem_s7[k-1][REM_W-3:0], sqr_rest_s7[k-1][SUM_W-1 -: 2]};
		assign trial = REM_W'({sqr_root_s7[k-1], 2'b01});
		assign ge    = (rem2 >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqr_ctl_s7[k] <= '0;
			end else begin
				sqr_ctl_s7[k] <= sqr_ctl_s7[k-1];
			end
		end

		always_ff @(posedge clk) begin
			sqr_rem_s7[k]  <= ge ? (rem2 - trial) : rem2;
			sqr_root_s7[k] <= {sqr_root_s7[k-1][ROOT_W-2:0], ge};
			sqr_rest_s7[k] <= sqr_rest_s7[k-1] << 2;
			sqr_mn_s7[k]   <= sqr_mn_s7[k-1];
		end
	end

	// Rounded numerators for the divider
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_p[i] = NUM_W'({sqr_mn_s7[SQ_STEPS][i], FRAC_BITS'(0)})
				+ NUM_W'(sqr_root_s7[SQ_STEPS] >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_ctl_s8[0] <= '0;
		end else begin
			dv_ctl_s8[0] <= sqr_ctl_s7[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		dv_n_s8[0] <= sqr_root_s7[SQ_STEPS];
		for (int i = 0; i < 3; i++) begin
			dv_rem_s8[0][i] <= ROOT_W'(num_p[i][NUM_W-1:QB]);
			dv_lo_s8[0][i]  <= num_p[i][QB-1:0];
		end
	end

	// Restoring division, one quotient bit a stage
	for (genvar j = 1; j <= QB; j++) begin : g_div
		logic [2:0][ROOT_W:0] r2;
		logic [2:0]           ge;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				r2[i] = {dv_rem_s8[j-1][i], dv_lo_s8[j-1][i][QB-1]};
				ge[i] = (r2[i] >= (ROOT_W+1)'(dv_n_s8[j-1]));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_ctl_s8[j] <= '0;
			end else begin
				dv_ctl_s8[j] <= dv_ctl_s8[j-1];
			end
		end

		always_ff @(posedge clk) begin
			dv_n_s8[j] <= dv_n_s8[j-1];
			for (int i = 0; i < 3; i++) begin
				dv_rem_s8[j][i] <= ROOT_W'(ge[i] ? (r2[i] - (ROOT_W+1)'(dv_n_s8[j-1]))
					: r2[i]);
				dv_lo_s8[j][i]  <= {dv_lo_s8[j-1][i][QB-2:0], ge[i]};
			end
		end
	end

	// Reapply signs, output zero for zero-length vectors
	assign q_f = dv_lo_s8[QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= dv_ctl_s8[QB].vld;
		end
	end

	always_ff @(posedge clk) begin
		out_zero <= dv_ctl_s8[QB].zero;
		out_side <= dv_ctl_s8[QB].side;
		for (int i = 0; i < 3; i++) begin
			if (dv_ctl_s8[QB].zero) begin
				out_vec[i] <= '0;
			end else if (dv_ctl_s8[QB].neg[i]) begin
				out_vec[i] <= AX_W'(0) - AX_W'(q_f[i]);
			end else begin
				out_vec[i] <= AX_W'(q_f[i]);
			end
		end
	end

endmodule

// ----- hw/rtl/look_at_view_matrix.sv -----
// Look-at view matrix: three rows (right, up, forward) per word taken.
// Rows come out in order, row 0 first and rows 1 and 2 after it; the path runs
// through three normalisers in series, each with a one-bit-a-stage square root
// and divider. Intake: a new word waits while busy, which holds off for the
// remaining row slots of the single result port.
// Reset: arst_n clears all valid bits and the row sequencer; the receiver cannot stall.
module look_at_view_matrix
	import lavm_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  lavm_in_t  item,
	output logic      strobe,
	output lavm_out_t result
);

`include "look_at_view_matrix_assert.svh"

	localparam int AX_W  = FRAC_BITS + 2;
	localparam int CP1_W = AX_W + 32;
	localparam int CP2_W = 2 * AX_W;
	localparam int TP_W  = AX_W + 32;
	localparam int S1_W  = 6 * 32;
	localparam int S2_W  = 1 + 3 * 32 + 3 * AX_W;
	localparam int S3_W  = 1 + 3 * 32 + 6 * AX_W;

	logic       accept;
	logic [1:0] gap_q;

	// Front stage
	logic                  vld_s1;
	logic [2:0][VEC_W-1:0] d_s1;
	logic [2:0][31:0]      eye_s1, up_s1;

	// First normaliser (forward axis)
	logic                  n1_vld, n1_zero;
	logic [2:0][AX_W-1:0]  n1_vec;
	logic [S1_W-1:0]       n1_side;
	logic [2:0][31:0]      n1_eye, n1_up;

	// up x z
	logic                   vld_s2, vld_s3;
	logic [5:0][CP1_W-1:0]  cp1_s2;
	logic [2:0][VEC_W-1:0]  c1_s3;
	logic [2:0][31:0]       eye_s2, eye_s3;
	logic [2:0][AX_W-1:0]   z_s2, z_s3;
	logic                   dg_s2, dg_s3;

	// Second normaliser (right axis)
	logic                  n2_vld, n2_zero;
	logic [2:0][AX_W-1:0]  n2_vec;
	logic [S2_W-1:0]       n2_side;
	logic                  n2_dg;
	logic [2:0][31:0]      n2_eye;
	logic [2:0][AX_W-1:0]  n2_z;

	// z x x
	logic                   vld_s4, vld_s5;
	logic [5:0][CP2_W-1:0]  cp2_s4;
	logic [2:0][VEC_W-1:0]  c2_s5;
	logic [2:0][31:0]       eye_s4, eye_s5;
	logic [2:0][AX_W-1:0]   z_s4, z_s5, x_s4, x_s5;
	logic                   dg_s4, dg_s5;

	// Third normaliser (up axis)
	logic                  n3_vld, n3_zero;
	logic [2:0][AX_W-1:0]  n3_vec;
	logic [S3_W-1:0]       n3_side;
	logic                  n3_dg;
	logic [2:0][31:0]      n3_eye;
	logic [2:0][AX_W-1:0]  n3_z, n3_x;

	// Translation stages, rows indexed by row code
	logic                        vld_s6, vld_s7, vld_s8;
	logic [2:0][2:0][TP_W-1:0]   tp_s6;
	logic [2:0][VEC_W-1:0]       t_s7;
	logic [2:0][31:0]            tr_s8;
	logic [2:0][2:0][AX_W-1:0]   ax_s6, ax_s7, ax_s8;
	logic                        dg_s6, dg_s7, dg_s8;
	logic [2:0][31:0]            tr8;

	// Row sequencer
	logic [1:0]                  cnt_q;
	logic [2:0][2:0][AX_W-1:0]   rbuf_ax_q;
	logic [2:0][31:0]            rbuf_tr_q;
	logic                        rbuf_dg_q;
	logic                        strobe_q;
	lavm_out_t                   result_q;

	// Intake: one word, then hold off for the remaining row slots
	assign accept = start && !busy;
	assign busy   = (gap_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (accept) begin
			gap_q <= 2'(ROWS - 1);
		end else if (gap_q != '0) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	// Forward difference and capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= n1_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= n2_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= n3_vld;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		d_s1[0] <= VEC_W'(item.eye_x) - VEC_W'(item.target_x);
		d_s1[1] <= VEC_W'(item.eye_y) - VEC_W'(item.target_y);
		d_s1[2] <= VEC_W'(item.eye_z) - VEC_W'(item.target_z);
		eye_s1  <= {item.eye_z, item.eye_y, item.eye_x};
		up_s1   <= {item.upvec_z, item.upvec_y, item.upvec_x};
	end

	lavm_norm #(
		.FRAC_BITS (FRAC_BITS),
		.SIDE_W    (S1_W)
	) u_norm_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.in_vec   (d_s1),
		.in_side  ({eye_s1, up_s1}),
		.out_vld  (n1_vld),
		.out_zero (n1_zero),
		.out_vec  (n1_vec),
		.out_side (n1_side)
	);

	assign {n1_eye, n1_up} = n1_side;

	// Cross product up x z: products, then differences
	always_ff @(posedge clk) begin
		cp1_s2[0] <= $signed(n1_up[1]) * $signed(n1_vec[2]);
		cp1_s2[1] <= $signed(n1_up[2]) * $signed(n1_vec[1]);
		cp1_s2[2] <= $signed(n1_up[2]) * $signed(n1_vec[0]);
		cp1_s2[3] <= $signed(n1_up[0]) * $signed(n1_vec[2]);
		cp1_s2[4] <= $signed(n1_up[0]) * $signed(n1_vec[1]);
		cp1_s2[5] <= $signed(n1_up[1]) * $signed(n1_vec[0]);
		eye_s2 <= n1_eye;
		z_s2   <= n1_vec;
		dg_s2  <= n1_zero;
		for (int i = 0; i < 3; i++) begin
			c1_s3[i] <= VEC_W'($signed(cp1_s2[2*i])) - VEC_W'($signed(cp1_s2[2*i+1]));
		end
		eye_s3 <= eye_s2;
		z_s3   <= z_s2;
		dg_s3  <= dg_s2;
	end

	lavm_norm #(
		.FRAC_BITS (FRAC_BITS),
		.SIDE_W    (S2_W)
	) u_norm_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.in_vec   (c1_s3),
		.in_side  ({dg_s3, eye_s3, z_s3}),
		.out_vld  (n2_vld),
		.out_zero (n2_zero),
		.out_vec  (n2_vec),
		.out_side (n2_side)
	);

	assign {n2_dg, n2_eye, n2_z} = n2_side;

	// Cross product z x x: products, then differences
	always_ff @(posedge clk) begin
		cp2_s4[0] <= $signed(n2_z[1]) * $signed(n2_vec[2]);
		cp2_s4[1] <= $signed(n2_z[2]) * $signed(n2_vec[1]);
		cp2_s4[2] <= $signed(n2_z[2]) * $signed(n2_vec[0]);
		cp2_s4[3] <= $signed(n2_z[0]) * $signed(n2_vec[2]);
		cp2_s4[4] <= $signed(n2_z[0]) * $signed(n2_vec[1]);
		cp2_s4[5] <= $signed(n2_z[1]) * $signed(n2_vec[0]);
		eye_s4 <= n2_eye;
		z_s4   <= n2_z;
		x_s4   <= n2_vec;
		dg_s4  <= n2_dg | n2_zero;
		for (int i = 0; i < 3; i++) begin
			c2_s5[i] <= VEC_W'($signed(cp2_s4[2*i])) - VEC_W'($signed(cp2_s4[2*i+1]));
		end
		eye_s5 <= eye_s4;
		z_s5   <= z_s4;
		x_s5   <= x_s4;
		dg_s5  <= dg_s4;
	end

	lavm_norm #(
		.FRAC_BITS (FRAC_BITS),
		.SIDE_W    (S3_W)
	) u_norm_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s5),
		.in_vec   (c2_s5),
		.in_side  ({dg_s5, eye_s5, z_s5, x_s5}),
		.out_vld  (n3_vld),
		.out_zero (n3_zero),
		.out_vec  (n3_vec),
		.out_side (n3_side)
	);

	assign {n3_dg, n3_eye, n3_z, n3_x} = n3_side;

	// Translation: products, negated sums, round and saturate
	always_comb begin
		logic [VEC_W-1:0] mag;
		logic [VEC_W-1:0] mr;
		for (int r = 0; r < 3; r++) begin
			mag = t_s7[r][VEC_W-1] ? (VEC_W'(0) - t_s7[r]) : t_s7[r];
			mr  = (mag + (VEC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
			if (t_s7[r][VEC_W-1]) begin
				tr8[r] = (mr > VEC_W'(64'h8000_0000)) ? 32'h8000_0000
					: 32'(VEC_W'(0) - mr);
			end else begin
				tr8[r] = (mr > VEC_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mr[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		ax_s6[ROW_X] <= n3_x;
		ax_s6[ROW_Y] <= n3_vec;
		ax_s6[ROW_Z] <= n3_z;
		for (int r = 0; r < 3; r++) begin
			for (int i = 0; i < 3; i++) begin
				tp_s6[r][i] <= (r == 0) ? $signed(n3_x[i]) * $signed(n3_eye[i])
					: (r == 1) ? $signed(n3_vec[i]) * $signed(n3_eye[i])
					: $signed(n3_z[i]) * $signed(n3_eye[i]);
			end
		end
		dg_s6 <= n3_dg | n3_zero;
		for (int r = 0; r < 3; r++) begin
			t_s7[r] <= VEC_W'(0) - (VEC_W'($signed(tp_s6[r][0]))
				+ VEC_W'($signed(tp_s6[r][1])) + VEC_W'($signed(tp_s6[r][2])));
		end
		ax_s7 <= ax_s6;
		dg_s7 <= dg_s6;
		tr_s8 <= tr8;
		ax_s8 <= ax_s7;
		dg_s8 <= dg_s7;
	end

	// Row sequencer: drop row X at once, hold rows Y and Z for the next cycles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= ROW_X;
			strobe_q <= 1'b0;
		end else if (vld_s8) begin
			cnt_q    <= ROW_Y;
			strobe_q <= 1'b1;
		end else if (cnt_q == ROW_Y) begin
			cnt_q    <= ROW_Z;
			strobe_q <= 1'b1;
		end else if (cnt_q == ROW_Z) begin
			cnt_q    <= ROW_X;
			strobe_q <= 1'b1;
		end else begin
			strobe_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s8) begin
			rbuf_ax_q <= ax_s8;
			rbuf_tr_q <= tr_s8;
			rbuf_dg_q <= dg_s8;
			result_q.row_index   <= ROW_X;
			result_q.col_0       <= 32'($signed(ax_s8[ROW_X][0]));
			result_q.col_1       <= 32'($signed(ax_s8[ROW_X][1]));
			result_q.col_2       <= 32'($signed(ax_s8[ROW_X][2]));
			result_q.translation <= tr_s8[ROW_X];
			result_q.degenerate  <= dg_s8;
			result_q.last_row    <= 1'b0;
		end else begin
			result_q.row_index   <= cnt_q;
			result_q.col_0       <= 32'($signed(rbuf_ax_q[cnt_q][0]));
			result_q.col_1       <= 32'($signed(rbuf_ax_q[cnt_q][1]));
			result_q.col_2       <= 32'($signed(rbuf_ax_q[cnt_q][2]));
			result_q.translation <= rbuf_tr_q[cnt_q];
			result_q.degenerate  <= rbuf_dg_q;
			result_q.last_row    <= (cnt_q == ROW_Z);
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	`LAV_ASSERT(a_accept_busy, clk, arst_n, accept |=> busy, "accept did not raise busy")
	`LAV_ASSERT(a_last_is_z, clk, arst_n, strobe && result.last_row |-> result.row_index == ROW_Z, "last row is not row Z")
	`LAV_ASSERT(a_x_then_y, clk, arst_n, strobe && result.row_index == ROW_X |=> strobe && result.row_index == ROW_Y, "row Y did not follow row X")
	`LAV_ASSERT(a_dg_steady, clk, arst_n, strobe && result.row_index != ROW_X |-> result.degenerate == $past(result.degenerate), "degenerate changed within a run")
	`LAV_NEVER(a_no_overlap, clk, arst_n, vld_s8 && cnt_q != ROW_X, "new word reached the sequencer mid-run")

endmodule

// ----- bench/look_at_view_matrix_tb.sv -----
module look_at_view_matrix_tb;
	import lavm_pkg::*;

	localparam int FB = 16;
	localparam int LATENCY = 3 * FB + 132;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	lavm_in_t  item;
	logic      strobe;
	lavm_out_t result;

	int errors = 0;

	look_at_view_matrix #(.FRAC_BITS(FB)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .strobe(strobe), .result(result)
	);

	// Print one mismatch line and count it
	task automatic report(input string what);
		errors++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	// Integer square root, floor
	function automatic logic [63:0] floor_root(input logic [63:0] s);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Scale a vector to unit length; zero vector gives zero and a flag
	function automatic bit unit_vec(input longint v[3], output longint u[3]);
		logic [63:0] m[3];
		logic [63:0] mx, sum, n, q;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? -v[i] : v[i];
			if (m[i] > mx) mx = m[i];
			u[i] = 0;
		end
		if (mx == 0) return 0;
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		sum = 0;
		for (int i = 0; i < 3; i++) sum += m[i] * m[i];
		n = floor_root(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FB) + (n >> 1)) / n;
			u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic void cross_prod(input longint a[3], input longint b[3],
			output longint r[3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	// Negated dot with eye, rounded half away from zero, saturated
	function automatic logic [31:0] eye_offset(input longint ax[3], input longint e[3]);
		longint t;
		logic [63:0] m;
		t = -(ax[0] * e[0] + ax[1] * e[1] + ax[2] * e[2]);
		m = t < 0 ? -t : t;
		m = (m + (64'd1 << (FB - 1))) >> FB;
		if (t < 0) return m > (64'd1 << 31) ? 32'h8000_0000 : 32'(-longint'(m));
		return m > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : 32'(m);
	endfunction

	class row_board;
		lavm_out_t rows_due[$];

		// Work out the three rows for an accepted word
		function void note_word(lavm_in_t w);
			longint e[3], d[3], up[3], z[3], x[3], y[3], c[3];
			longint ax[3];
			bit ok;
			lavm_out_t r;
			e = '{w.eye_x, w.eye_y, w.eye_z};
			d = '{longint'(w.eye_x) - w.target_x, longint'(w.eye_y) - w.target_y,
				longint'(w.eye_z) - w.target_z};
			up = '{w.upvec_x, w.upvec_y, w.upvec_z};
			ok = unit_vec(d, z);
			cross_prod(up, z, c);
			ok &= unit_vec(c, x);
			cross_prod(z, x, c);
			ok &= unit_vec(c, y);
			for (int k = 0; k < ROWS; k++) begin
				if (k == 0) ax = x;
				else if (k == 1) ax = y;
				else ax = z;
				r.row_index = k == 0 ? ROW_X : (k == 1 ? ROW_Y : ROW_Z);
				r.col_0 = 32'(ax[0]);
				r.col_1 = 32'(ax[1]);
				r.col_2 = 32'(ax[2]);
				r.translation = eye_offset(ax, e);
				r.degenerate = !ok;
				r.last_row = k == 2;
				rows_due.push_back(r);
			end
		endfunction

		// Compare a row with the oldest one due
		task check_row(lavm_out_t got);
			lavm_out_t want;
			if (rows_due.size() == 0) begin
				report("row with none due");
				return;
			end
			want = rows_due.pop_front();
			if (got.row_index !== want.row_index)
				report($sformatf("row_index %0d want %0d", got.row_index, want.row_index));
			if (got.col_0 !== want.col_0)
				report($sformatf("col_0 %h want %h", got.col_0, want.col_0));
			if (got.col_1 !== want.col_1)
				report($sformatf("col_1 %h want %h", got.col_1, want.col_1));
			if (got.col_2 !== want.col_2)
				report($sformatf("col_2 %h want %h", got.col_2, want.col_2));
			if (got.translation !== want.translation)
				report($sformatf("translation %h want %h", got.translation, want.translation));
			if (got.degenerate !== want.degenerate)
				report($sformatf("degenerate %b want %b", got.degenerate, want.degenerate));
			if (got.last_row !== want.last_row)
				report($sformatf("last_row %b want %b", got.last_row, want.last_row));
		endtask
	endclass

	row_board board = new();
	bit calm = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Sample rows at the rising edge
	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) board.check_row(result);
	end

	// Present one word and hold it until taken
	task automatic send_word(input lavm_in_t w);
		while (!calm && $urandom_range(99) < 9) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_word(w);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(65535)) - 32768) <<< 16;
			2: return 32'($signed($urandom_range(2000)) - 1000);
			3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			4: return 0;
			default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23)) <<< 4;
		endcase
	endfunction

	task automatic send_vecs(input logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
		lavm_in_t w;
		w = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
		send_word(w);
	endtask

	initial begin
		lavm_in_t w;
		logic [31:0] one;
		one = 32'h0001_0000;
		start = 0;
		item = '0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// Directed: ordinary, eye equal to target, parallel up, zero up, extremes
		send_vecs(0, 0, 5 * one, 0, 0, 0, 0, one, 0);
		send_vecs(3 * one, one, 2 * one, 3 * one, one, 2 * one, 0, one, 0);
		send_vecs(0, 0, one, 0, 0, 0, 0, 0, 7 * one);
		send_vecs(one, 2 * one, 3 * one, 0, 0, 0, 0, 0, 0);
		send_vecs(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_vecs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_vecs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_vecs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 1, 0, 0);
		send_vecs(32'h7000_0000, 32'h9000_0000, 32'h7000_0000, 0, 0, 0, 0, one, 0);
		send_vecs(1, 0, 0, 0, 0, 0, 0, 1, 0);
		start <= 1'b0;
		// Hold off until every row is out
		while (board.rows_due.size() != 0) @(posedge clk);
		@(negedge clk);
		for (int n = 0; n < 250; n++) begin
			calm = n >= 100 && n < 150;
			for (int f = 0; f < 9; f++) w[f * 32 +: 32] = rand_coord();
			if ($urandom_range(19) == 0) begin
				w.target_x = w.eye_x;
				w.target_y = w.eye_y;
				w.target_z = w.eye_z;
			end else if ($urandom_range(19) == 0) begin
				w.upvec_x = w.eye_x - w.target_x;
				w.upvec_y = w.eye_y - w.target_y;
				w.upvec_z = w.eye_z - w.target_z;
			end
			send_word(w);
		end
		start <= 1'b0;
		while (board.rows_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0 && board.rows_due.size() == 0)
			$display("look_at_view_matrix_tb: PASS");
		else
			$display("look_at_view_matrix_tb: FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("look_at_view_matrix_tb: FAIL");
		$finish;
	end
endmodule

// ----- look_at_view_matrix.f -----
+incdir+hw/rtl
hw/rtl/lavm_pkg.sv
hw/rtl/lavm_norm.sv
hw/rtl/look_at_view_matrix.sv
bench/look_at_view_matrix_tb.sv
